// File: sv/mcadb_pkg.sv
// Package for the channel deframer and batcher.
// Holds widths, frame codes and result kinds shared by the interfaces and the top level.
// No dependencies.
package mcadb_pkg;

	// Bucket geometry
	localparam int BUCKET_DEPTH = 16;
	localparam int IDX_W        = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

	// Field widths
	localparam int CHAN_W    = 12;
	localparam int ENTRY_W   = 4;
	localparam int BYTE_W    = 8;
	localparam int SIX_W     = 6;
	localparam int TIMEOUT_W = 16;
	localparam int TICK_W    = 17;

	// Register reset value
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd20000;

	// Frame byte codes
	localparam logic [BYTE_W-1:0] TAG_MASK   = 8'hC0;
	localparam logic [BYTE_W-1:0] TAG_START  = 8'h80;
	localparam logic [BYTE_W-1:0] TAG_HIGH   = 8'hC0;

	// Input item kinds
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Result kinds
	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_REINIT = 1'b1;

endpackage

// File: sv/mcadb_if.sv
// Handshake interfaces of the channel deframer and batcher: input items,
// result items and the configuration write channel. Depends on mcadb_pkg.
interface mcadb_item_if import mcadb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, func, rx_byte, input ready);
	modport sink (input valid, func, rx_byte, output ready);
endinterface

interface mcadb_result_if import mcadb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [CHAN_W-1:0]  channel_value;
	logic [ENTRY_W-1:0] entry_index;
	logic               last_of_run;

	modport source (output valid, result_kind, channel_value, entry_index, last_of_run,
		input ready);
	modport sink (input valid, result_kind, channel_value, entry_index, last_of_run,
		output ready);
endinterface

interface mcadb_cfg_if import mcadb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [TIMEOUT_W-1:0] wdata;

	modport source (output valid, wdata, input ready);
	modport sink (input valid, wdata, output ready);
endinterface

// File: sv/mcadb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mcadb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold data when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/mca_channel_deframer_batcher_unit.sv
// Top level of the channel deframer and batcher.
// Depends on mcadb_pkg, the interfaces in mcadb_if and mcadb_ram.

// A byte or tick word is taken whenever the unit is idle and its result register is
// free. A frame byte that fills the bucket starts a readout of the bucket RAM: each entry
// is read (ST_READ), then loaded into the result register (ST_LOAD) once that register is
// free. No input word is taken until the last entry has been loaded. The pace is set by the
// single read port of the bucket RAM and its registered read data. A tick that passes
// the idle timeout yields one re-initialise result. The timeout register is written
// through the cfg channel, which is always ready; the unit needs no clearing pass.
module mca_channel_deframer_batcher_unit import mcadb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	mcadb_cfg_if.sink        cfg,
	mcadb_item_if.sink       items,
	mcadb_result_if.source   results
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t               state_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 await_q;
	logic [SIX_W-1:0]     low_q;
	logic [IDX_W-1:0]     fill_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [TICK_W-1:0]    ticks_q;

	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [CHAN_W-1:0]    out_chan_q;
	logic [ENTRY_W-1:0]   out_idx_q;
	logic                 out_last_q;

	logic                 out_free;
	logic                 accept;
	logic                 is_start;
	logic                 is_high;
	logic                 frame_done;
	logic                 bucket_full;
	logic [TICK_W-1:0]    ticks_next;
	logic                 timed_out;
	logic                 load_entry;
	logic                 last_entry;
	logic [CHAN_W-1:0]    chan;
	logic [CHAN_W-1:0]    ram_rdata;

	// Handshake decode
	assign out_free    = !out_valid_q || results.ready;
	assign items.ready = (state_q == ST_IDLE) && out_free;
	assign accept      = items.valid && items.ready;
	assign cfg.ready   = 1'b1;

	// Frame parser decode
	assign is_start    = !await_q && ((items.rx_byte & TAG_MASK) == TAG_START);
	assign is_high     = await_q && ((items.rx_byte & TAG_MASK) == TAG_HIGH);
	assign frame_done  = accept && (items.func == FUNC_BYTE) && is_high;
	assign chan        = {items.rx_byte[SIX_W-1:0], low_q};
	assign bucket_full = (fill_q == IDX_W'(BUCKET_DEPTH - 1));

	// Idle tick check
	assign ticks_next  = ticks_q + 1'b1;
	assign timed_out   = ticks_next > {1'b0, timeout_q};

	// Bucket readout
	assign load_entry  = (state_q == ST_LOAD) && out_free;
	assign last_entry  = (rd_idx_q == IDX_W'(BUCKET_DEPTH - 1));

	mcadb_ram #(
		.WIDTH (CHAN_W),
		.DEPTH (BUCKET_DEPTH)
	) u_bucket (
		.clk   (clk),
		.we    (frame_done),
		.waddr (fill_q),
		.wdata (chan),
		.re    (state_q == ST_READ),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			timeout_q <= cfg.wdata;
		end
	end

	// Parser, fill count, tick counter and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			await_q  <= 1'b0;
			low_q    <= '0;
			fill_q   <= '0;
			rd_idx_q <= '0;
			ticks_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && items.func == FUNC_TICK) begin
						ticks_q <= timed_out ? '0 : ticks_next;
					end else if (accept) begin
						if (is_start) begin
							low_q   <= items.rx_byte[SIX_W-1:0];
							await_q <= 1'b1;
						end else begin
							await_q <= 1'b0;
						end
						if (is_high) begin
							ticks_q <= '0;
							if (bucket_full) begin
								fill_q   <= '0;
								rd_idx_q <= '0;
								state_q  <= ST_READ;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load_entry) begin
						if (last_entry) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register valid: load a timeout request or a bucket entry, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_entry || (accept && items.func == FUNC_TICK && timed_out)) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (load_entry) begin
			out_kind_q <= KIND_ENTRY;
			out_chan_q <= ram_rdata;
			out_idx_q  <= ENTRY_W'(rd_idx_q);
			out_last_q <= last_entry;
		end else if (accept && items.func == FUNC_TICK && timed_out) begin
			out_kind_q <= KIND_REINIT;
			out_chan_q <= '0;
			out_idx_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.result_kind   = out_kind_q;
	assign results.channel_value = out_chan_q;
	assign results.entry_index   = out_idx_q;
	assign results.last_of_run   = out_last_q;

	// No input word is taken during a bucket readout
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !items.ready)
		else $error("input taken during bucket readout");

	// The fill count is cleared before a readout starts
	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (fill_q == '0))
		else $error("fill count not cleared during readout");

	// Loading the final entry returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_entry && last_entry) |=> (state_q == ST_IDLE))
		else $error("readout did not end after final entry");

	// A re-initialise request always closes its run
	a_reinit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_REINIT) |-> out_last_q)
		else $error("re-initialise request not marked last");

endmodule
